@@ hdl/hbvc_pkg.sv @@
// Package for the blend valve controller: fixed-point constants, field widths,
// configuration register indexes, request codes and the drift state type.
// No dependencies.
package hbvc_pkg;

   // Field widths
   localparam int TEMP_W      = 16;
   localparam int STEP_W      = 12;
   localparam int DB_W        = 10;
   localparam int MIXOFF_W    = 13;
   localparam int OPEN_W      = 15;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int ADC_BITS_DEFAULT = 10;

   // Fixed point: 1/1280 degC per LSB for temperatures, 1/320 percent for openings.
   localparam logic [TEMP_W-1:0] T_RESET   = 16'd25600;
   localparam logic [TEMP_W-1:0] ADC_BASE  = 16'd12800;
   localparam logic [TEMP_W-1:0] ADC_SPAN  = 16'd51200;
   localparam logic [TEMP_W-1:0] COLD_ZERO = 16'd51200;
   localparam logic [TEMP_W-1:0] HOT_ZERO  = 16'd19200;
   localparam logic [OPEN_W-1:0] OPEN_FULL = 15'd32000;

   // Configuration reset values
   localparam logic [TEMP_W-1:0]   SETPOINT_MIN_RST  = 16'd20480;
   localparam logic [TEMP_W-1:0]   SETPOINT_MAX_RST  = 16'd38400;
   localparam logic [STEP_W-1:0]   SETPOINT_STEP_RST = 12'd640;
   localparam logic [DB_W-1:0]     ADC_DEADBAND_RST  = 10'd5;
   localparam logic [STEP_W-1:0]   COMFORT_BAND_RST  = 12'd64;
   localparam logic [STEP_W-1:0]   DRIFT_STEP_RST    = 12'd128;
   localparam logic [MIXOFF_W-1:0] MIX_OFFSET_RST    = 13'd2560;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ADC_DEADBAND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COMFORT_BAND  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DRIFT_STEP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIX_OFFSET    = 3'd6;

   // User request codes
   localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
   localparam logic [OP_W-1:0] OP_RAISE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOWER = 2'd2;

   typedef enum logic [1:0] {
      DRIFT_NONE = 2'd0,
      DRIFT_UP   = 2'd1,
      DRIFT_DOWN = 2'd2
   } drift_type;

endpackage

@@ hdl/hbvc_if.sv @@
// Channel interfaces of the blend valve controller: request, result and
// configuration write. Depends on hbvc_pkg for field widths.
interface hbvc_req_if #(
   parameter int ADC_BITS = hbvc_pkg::ADC_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic [hbvc_pkg::OP_W-1:0]    op;
   logic                         system_on;
   logic                         hold_expired;
   logic [ADC_BITS-1:0]          adc_sample;

   modport source (output valid, op, system_on, hold_expired, adc_sample, input ready);
   modport sink   (input valid, op, system_on, hold_expired, adc_sample, output ready);
endinterface

interface hbvc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hbvc_pkg::TEMP_W-1:0]   current_temp;
   logic [hbvc_pkg::TEMP_W-1:0]   target_temp;
   logic [hbvc_pkg::OPEN_W-1:0]   cold_valve_opening;
   logic [hbvc_pkg::OPEN_W-1:0]   hot_valve_opening;
   logic [hbvc_pkg::TEMP_W-1:0]   mix_temp;

   modport source (output valid, current_temp, target_temp, cold_valve_opening,
                   hot_valve_opening, mix_temp, input ready);
   modport sink   (input valid, current_temp, target_temp, cold_valve_opening,
                   hot_valve_opening, mix_temp, output ready);
endinterface

interface hbvc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [hbvc_pkg::CSR_IDX_W-1:0]   index;
   logic [hbvc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/hvac_blend_valve_controller.sv @@
// Channel   Direction  Carries
// req_chan  in         op, system_on, hold_expired, adc_sample (one control tick)
// rsp_chan  out        current_temp, target_temp, cold/hot valve openings, mix_temp
// csr_chan  in         register index and write data
//
// A request is registered, evaluated in one pass against the controller state and
// the result is registered; one request per cycle while the result is not stalled.
// The state update and the result register load on the same edge, so the next
// request always sees the state left by the one before it.
// Reset is synchronous; it restores the state and configuration defaults.
// A stalled result holds the evaluation stage; one more request can wait in front.
//
// Top level of the blend valve controller. Depends on hbvc_pkg and hbvc_if.
module hvac_blend_valve_controller #(
   parameter int ADC_BITS = hbvc_pkg::ADC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   hbvc_req_if.sink    req_chan,
   hbvc_rsp_if.source  rsp_chan,
   hbvc_csr_if.sink    csr_chan
);
   import hbvc_pkg::*;

   localparam int DW = (ADC_BITS > DB_W) ? ADC_BITS : DB_W;

   // Configuration
   logic [TEMP_W-1:0]   sp_min_ff, sp_max_ff;
   logic [STEP_W-1:0]   sp_step_ff, band_ff, drift_step_ff;
   logic [DB_W-1:0]     deadband_ff;
   logic [MIXOFF_W-1:0] mix_off_ff;

   // Controller state
   logic [TEMP_W-1:0]   sp_ff, temp_ff, mix_ff;
   logic [TEMP_W-1:0]   sp_in, temp_in, mix_in;
   drift_type           drift_ff, drift_in;
   logic                hold_ff, hold_in;
   logic [ADC_BITS-1:0] last_ff;

   // Input stage
   logic                in_valid_ff;
   logic [OP_W-1:0]     in_op_ff;
   logic                in_on_ff, in_exp_ff;
   logic [ADC_BITS-1:0] in_sample_ff;

   // Result stage
   logic                out_valid_ff;
   logic [TEMP_W-1:0]   out_temp_ff, out_sp_ff, out_mix_ff;
   logic [OPEN_W-1:0]   out_cold_ff, out_hot_ff, cold_in, hot_in;

   logic advance;
   logic req_fire;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_min_ff     <= SETPOINT_MIN_RST;
         sp_max_ff     <= SETPOINT_MAX_RST;
         sp_step_ff    <= SETPOINT_STEP_RST;
         deadband_ff   <= ADC_DEADBAND_RST;
         band_ff       <= COMFORT_BAND_RST;
         drift_step_ff <= DRIFT_STEP_RST;
         mix_off_ff    <= MIX_OFFSET_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_SETPOINT_MIN:  sp_min_ff     <= csr_chan.data;
            REG_SETPOINT_MAX:  sp_max_ff     <= csr_chan.data;
            REG_SETPOINT_STEP: sp_step_ff    <= csr_chan.data[STEP_W-1:0];
            REG_ADC_DEADBAND:  deadband_ff   <= csr_chan.data[DB_W-1:0];
            REG_COMFORT_BAND:  band_ff       <= csr_chan.data[STEP_W-1:0];
            REG_DRIFT_STEP:    drift_step_ff <= csr_chan.data[STEP_W-1:0];
            REG_MIX_OFFSET:    mix_off_ff    <= csr_chan.data[MIXOFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff     <= req_chan.op;
         in_on_ff     <= req_chan.system_on;
         in_exp_ff    <= req_chan.hold_expired;
         in_sample_ff <= req_chan.adc_sample;
      end
   end

   // Evaluation of one tick
   logic [TEMP_W:0]         sp_up, sp_dn, t_up, t_plus, t_minus, mix_up;
   logic [TEMP_W:0]         cold_d, hot_d, adc_sum;
   logic [ADC_BITS+TEMP_W-1:0] adc_prod;
   logic [ADC_BITS-1:0]     abs_diff;
   logic                    moved, above, below;
   drift_type               drift_eff;

   always_comb begin
      sp_in   = sp_ff;
      hold_in = in_exp_ff ? 1'b0 : hold_ff;
      sp_up   = {1'b0, sp_ff} + {5'b0, sp_step_ff};
      sp_dn   = {1'b0, sp_ff} - {5'b0, sp_step_ff};
      unique case (in_op_ff)
         OP_RAISE: begin
            if (sp_ff < sp_max_ff) begin
               sp_in = (sp_up > {1'b0, sp_max_ff}) ? sp_max_ff : sp_up[TEMP_W-1:0];
            end
            hold_in = 1'b1;
         end
         OP_LOWER: begin
            if (sp_ff > sp_min_ff) begin
               sp_in = (sp_dn[TEMP_W] || sp_dn[TEMP_W-1:0] < sp_min_ff) ?
                       sp_min_ff : sp_dn[TEMP_W-1:0];
            end
            hold_in = 1'b1;
         end
         default: ;
      endcase

      drift_eff = (!in_on_ff || hold_in) ? DRIFT_NONE : drift_ff;

      abs_diff = (in_sample_ff >= last_ff) ? (in_sample_ff - last_ff)
                                           : (last_ff - in_sample_ff);
      moved    = DW'(abs_diff) > DW'(deadband_ff);
      // The scaled reading stays below ADC_BASE + ADC_SPAN, so it never saturates.
      adc_prod = (ADC_BITS+TEMP_W)'(ADC_SPAN) * (ADC_BITS+TEMP_W)'(in_sample_ff);
      adc_sum  = {1'b0, ADC_BASE} + {1'b0, adc_prod[ADC_BITS+TEMP_W-1:ADC_BITS]};
      t_up     = {1'b0, temp_ff} + {5'b0, drift_step_ff};

      if (moved) begin
         temp_in = adc_sum[TEMP_W-1:0];
      end else if (drift_eff == DRIFT_UP) begin
         temp_in = t_up[TEMP_W] ? {TEMP_W{1'b1}} : t_up[TEMP_W-1:0];
      end else if (drift_eff == DRIFT_DOWN) begin
         temp_in = (temp_ff < TEMP_W'(drift_step_ff)) ? '0 :
                   temp_ff - TEMP_W'(drift_step_ff);
      end else begin
         temp_in = temp_ff;
      end

      t_plus  = {1'b0, temp_in} + {5'b0, band_ff};
      t_minus = {1'b0, temp_in} - {5'b0, band_ff};
      above   = {1'b0, sp_in} > t_plus;
      below   = !t_minus[TEMP_W] && (sp_in < t_minus[TEMP_W-1:0]);
      mix_up  = {1'b0, sp_in} + {4'b0, mix_off_ff};

      if (above || below) begin
         if (sp_in < temp_in) begin
            drift_in = DRIFT_DOWN;
            mix_in   = (sp_in < TEMP_W'(mix_off_ff)) ? '0 : sp_in - TEMP_W'(mix_off_ff);
         end else begin
            drift_in = DRIFT_UP;
            mix_in   = mix_up[TEMP_W] ? {TEMP_W{1'b1}} : mix_up[TEMP_W-1:0];
         end
      end else begin
         drift_in = DRIFT_NONE;
         mix_in   = sp_in;
      end

      // Linear valve law: cold = 51200 - mix, hot = mix - 19200, both capped at full.
      cold_d = {1'b0, COLD_ZERO} - {1'b0, mix_in};
      hot_d  = {1'b0, mix_in} - {1'b0, HOT_ZERO};
      if (cold_d[TEMP_W]) begin
         cold_in = '0;
      end else if (cold_d[TEMP_W-1:0] > TEMP_W'(OPEN_FULL)) begin
         cold_in = OPEN_FULL;
      end else begin
         cold_in = cold_d[OPEN_W-1:0];
      end
      if (hot_d[TEMP_W]) begin
         hot_in = '0;
      end else if (hot_d[TEMP_W-1:0] > TEMP_W'(OPEN_FULL)) begin
         hot_in = OPEN_FULL;
      end else begin
         hot_in = hot_d[OPEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= T_RESET;
         temp_ff  <= T_RESET;
         mix_ff   <= T_RESET;
         drift_ff <= DRIFT_NONE;
         hold_ff  <= 1'b0;
         last_ff  <= '0;
      end else if (advance) begin
         sp_ff    <= sp_in;
         temp_ff  <= temp_in;
         mix_ff   <= mix_in;
         drift_ff <= drift_in;
         hold_ff  <= hold_in;
         last_ff  <= in_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_temp_ff <= temp_in;
         out_sp_ff   <= sp_in;
         out_mix_ff  <= mix_in;
         out_cold_ff <= cold_in;
         out_hot_ff  <= hot_in;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.current_temp       = out_temp_ff;
   assign rsp_chan.target_temp        = out_sp_ff;
   assign rsp_chan.cold_valve_opening = out_cold_ff;
   assign rsp_chan.hot_valve_opening  = out_hot_ff;
   assign rsp_chan.mix_temp           = out_mix_ff;

`ifndef SYNTHESIS
   // A stalled result must freeze the controller state.
   a_stall_freezes_state: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> ($stable(sp_ff) && $stable(temp_ff)))
      else $error("controller state changed while the result was stalled");

   // A request taken while the input stage is full must coincide with evaluation.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_fire && in_valid_ff) |-> advance)
      else $error("input stage overwritten before evaluation");

   // Every evaluated tick produces a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated tick produced no result");

   // Valve openings never exceed full scale.
   a_open_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_cold_ff <= OPEN_FULL && out_hot_ff <= OPEN_FULL))
      else $error("valve opening above full scale");
`endif

endmodule
